// File: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W_DEF = 16;
    localparam int VAL_W_DEF = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_RANK   = 2'd2,
        REQ_IGNORE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANK  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     descending;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_cell.sv
`default_nettype none

module spq_cell #(
    parameter int KEY_W = spq_pkg::KEY_W_DEF,
    parameter int VAL_W = spq_pkg::VAL_W_DEF
) (
    input  wire                      aclk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire logic signed [KEY_W-1:0] new_key,
    input  wire logic [VAL_W-1:0]    new_value,
    input  wire logic                occupied,
    input  wire logic                at_tail,
    input  wire logic                found_in,
    output logic                     found_out,
    input  wire logic signed [KEY_W-1:0] prev_key,
    input  wire logic [VAL_W-1:0]    prev_value,
    input  wire logic signed [KEY_W-1:0] next_key,
    input  wire logic [VAL_W-1:0]    next_value,
    output logic signed [KEY_W-1:0]  key_q,
    output logic [VAL_W-1:0]         value_q
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic [VAL_W-1:0]        value_reg;
    logic [VAL_W-1:0]        value_next;
    logic                    goes_before;

    // The new entry goes ahead of an occupied cell if its key is equal or earlier in order.
    assign goes_before = occupied &
                         (ctrl.descending ? (new_key >= key_reg) : (new_key <= key_reg));
    assign found_out   = found_in | goes_before;

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        case (ctrl.op)
            spq_pkg::CELL_INSERT: begin
                if (found_in) begin
                    key_next   = prev_key;
                    value_next = prev_value;
                end else if (goes_before || at_tail) begin
                    key_next   = new_key;
                    value_next = new_value;
                end
            end
            spq_pkg::CELL_REMOVE: begin
                key_next   = next_key;
                value_next = next_value;
            end
            default: begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue_unit.sv
// A result is registered on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the slave side stalls only
// while an untaken result is held. The clock is set by the compare chain through DEPTH cells.
// Reset (aresetn low, synchronous) empties the queue, selects ascending order and drops
// any pending result; entry storage is not cleared.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int KEY_W = spq_pkg::KEY_W_DEF,
    parameter int VAL_W = spq_pkg::VAL_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IN_W  = ((KEY_W + VAL_W + CNT_W + 7) / 8) * 8,
    localparam int OUT_W = ((KEY_W + VAL_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              cfg_we,
    input  wire              cfg_wdata,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire  [IN_W-1:0]  s_tdata,   // key, value, rank_index, zero fill
    input  wire  [1:0]       s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata,   // out_key, out_value, entry_count, is_empty, zero fill
    output logic [1:0]       m_tuser    // status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                    desc_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic                    accept;
    spq_pkg::req_t           req;
    logic signed [KEY_W-1:0] in_key;
    logic [VAL_W-1:0]        in_value;
    logic [CNT_W-1:0]        in_rank;
    logic [CNT_W-1:0]        rank_m1;
    logic [IDX_W-1:0]        rank_addr;

    spq_pkg::cell_ctrl_t     ctrl;
    logic signed [KEY_W-1:0] cell_key [DEPTH];
    logic [VAL_W-1:0]        cell_value [DEPTH];
    logic                    found [DEPTH];

    spq_pkg::status_t        res_status;
    logic signed [KEY_W-1:0] res_key;
    logic [VAL_W-1:0]        res_value;
    logic                    full;
    logic                    empty;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = ~m_tvalid_reg | m_tready;

    assign req       = spq_pkg::req_t'(s_tuser);
    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_value  = s_tdata[KEY_W+VAL_W-1:KEY_W];
    assign in_rank   = s_tdata[KEY_W+VAL_W+CNT_W-1:KEY_W+VAL_W];
    assign rank_m1   = in_rank - CNT_W'(1);
    assign rank_addr = rank_m1[IDX_W-1:0];

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        ctrl.descending = desc_reg;
        ctrl.op         = spq_pkg::CELL_HOLD;
        if (accept) begin
            case (req)
                spq_pkg::REQ_INSERT: begin
                    if (!full) begin
                        ctrl.op = spq_pkg::CELL_INSERT;
                    end
                end
                spq_pkg::REQ_REMOVE: begin
                    if (!empty) begin
                        ctrl.op = spq_pkg::CELL_REMOVE;
                    end
                end
                default: begin
                    ctrl.op = spq_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                    occupied;
        logic                    at_tail;
        logic                    found_in;
        logic signed [KEY_W-1:0] prev_key;
        logic [VAL_W-1:0]        prev_value;
        logic signed [KEY_W-1:0] next_key;
        logic [VAL_W-1:0]        next_value;

        assign occupied = (CNT_W'(i) < count_reg);
        assign at_tail  = (CNT_W'(i) == count_reg);

        if (i == 0) begin : g_head
            assign found_in   = 1'b0;
            assign prev_key   = in_key;
            assign prev_value = in_value;
        end else begin : g_body
            assign found_in   = found[i-1];
            assign prev_key   = cell_key[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_key   = cell_key[i];
            assign next_value = cell_value[i];
        end else begin : g_inner
            assign next_key   = cell_key[i+1];
            assign next_value = cell_value[i+1];
        end

        spq_cell #(
            .KEY_W(KEY_W),
            .VAL_W(VAL_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .new_key   (in_key),
            .new_value (in_value),
            .occupied  (occupied),
            .at_tail   (at_tail),
            .found_in  (found_in),
            .found_out (found[i]),
            .prev_key  (prev_key),
            .prev_value(prev_value),
            .next_key  (next_key),
            .next_value(next_value),
            .key_q     (cell_key[i]),
            .value_q   (cell_value[i])
        );
    end

    always_comb begin
        res_status = spq_pkg::ST_OK;
        res_key    = '0;
        res_value  = '0;
        count_next = count_reg;
        case (req)
            spq_pkg::REQ_INSERT: begin
                if (full) begin
                    res_status = spq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (empty || found[0]) begin
                        res_key   = in_key;
                        res_value = in_value;
                    end else begin
                        res_key   = cell_key[0];
                        res_value = cell_value[0];
                    end
                end
            end
            spq_pkg::REQ_REMOVE: begin
                if (empty) begin
                    res_status = spq_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    res_key    = cell_key[0];
                    res_value  = cell_value[0];
                end
            end
            spq_pkg::REQ_RANK: begin
                if (in_rank == '0 || in_rank > count_reg) begin
                    res_status = spq_pkg::ST_RANK;
                end else begin
                    res_key   = cell_key[rank_addr];
                    res_value = cell_value[rank_addr];
                end
            end
            default: begin
                if (!empty) begin
                    res_key   = cell_key[0];
                    res_value = cell_value[0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                desc_reg <= cfg_wdata;
            end
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= OUT_W'({(count_next == '0), count_next, res_value, res_key});
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: rtl/core/spq_checker.sv
`default_nettype none

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int KEY_W = spq_pkg::KEY_W_DEF,
    parameter int VAL_W = spq_pkg::VAL_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((KEY_W + VAL_W + CNT_W + 1 + 7) / 8) * 8
) (
    input wire             aclk,
    input wire             aresetn,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata,
    input wire [1:0]       m_tuser
);

    localparam int CNT_LO   = KEY_W + VAL_W;
    localparam int EMPTY_AT = KEY_W + VAL_W + CNT_W;

    logic [CNT_W-1:0] out_count;
    logic             out_empty;

    assign out_count = m_tdata[EMPTY_AT-1:CNT_LO];
    assign out_empty = m_tdata[EMPTY_AT];

    // A held result must not change until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The empty flag agrees with the reported count.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_empty == (out_count == '0)))
        else $error("empty flag disagrees with count");

    // A refused insert means the queue was full.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == spq_pkg::ST_FULL) |-> (out_count == CNT_W'(DEPTH)))
        else $error("insert refused while not full");

    // A refused remove means the queue was empty, with zero payload.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == spq_pkg::ST_EMPTY) |->
            out_empty && (m_tdata[CNT_LO-1:0] == '0))
        else $error("remove refused while not empty");

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .DEPTH(DEPTH),
    .KEY_W(KEY_W),
    .VAL_W(VAL_W)
) u_spq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

`default_nettype wire

// File: bench/priority_queue_checker.sv
module priority_queue_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int KEY_W = spq_pkg::KEY_W_DEF,
    parameter int VAL_W = spq_pkg::VAL_W_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IN_W  = ((KEY_W + VAL_W + CNT_W + 7) / 8) * 8,
    parameter int OUT_W = ((KEY_W + VAL_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             cfg_we,
    input  wire             cfg_wdata,
    input  wire             s_tvalid,
    input  wire             s_tready,
    input  wire [IN_W-1:0]  s_tdata,
    input  wire [1:0]       s_tuser,
    input  wire             m_tvalid,
    input  wire             m_tready,
    input  wire [OUT_W-1:0] m_tdata,
    input  wire [1:0]       m_tuser,
    output int              mismatch_count,
    output int              results_pending
);
    import spq_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             empty;
    } queue_result_t;

    logic [KEY_W-1:0] key_slots [DEPTH];
    logic [VAL_W-1:0] value_slots [DEPTH];
    int               held;
    bit               descending;
    queue_result_t    expected_results [$];

    function automatic bit belongs_before(logic [KEY_W-1:0] new_key, logic [KEY_W-1:0] old_key);
        if (descending) begin
            return $signed(new_key) >= $signed(old_key);
        end
        return $signed(new_key) <= $signed(old_key);
    endfunction

    // Applies one request to the local copy of the queue and returns the result it should give.
    function automatic queue_result_t predict_queue_op(req_t req, logic [KEY_W-1:0] new_key,
                                                       logic [VAL_W-1:0] new_value,
                                                       logic [CNT_W-1:0] rank);
        queue_result_t res;
        int            slot;
        bit            placed;
        res = '0;
        res.status = ST_OK;
        case (req)
            REQ_INSERT: begin
                if (held >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = held;
                    placed = 1'b0;
                    for (int i = 0; i < held; i++) begin
                        if (!placed && belongs_before(new_key, key_slots[i])) begin
                            slot = i;
                            placed = 1'b1;
                        end
                    end
                    for (int i = held; i > slot; i--) begin
                        key_slots[i] = key_slots[i-1];
                        value_slots[i] = value_slots[i-1];
                    end
                    key_slots[slot] = new_key;
                    value_slots[slot] = new_value;
                    held++;
                    res.key = key_slots[0];
                    res.value = value_slots[0];
                end
            end
            REQ_REMOVE: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key = key_slots[0];
                    res.value = value_slots[0];
                    for (int i = 1; i < held; i++) begin
                        key_slots[i-1] = key_slots[i];
                        value_slots[i-1] = value_slots[i];
                    end
                    held--;
                end
            end
            REQ_RANK: begin
                if (rank < 1 || rank > held) begin
                    res.status = ST_RANK;
                end else begin
                    res.key = key_slots[rank-1];
                    res.value = value_slots[rank-1];
                end
            end
            default: begin
                if (held > 0) begin
                    res.key = key_slots[0];
                    res.value = value_slots[0];
                end
            end
        endcase
        res.count = CNT_W'(held);
        res.empty = (held == 0);
        return res;
    endfunction

    initial begin
        mismatch_count = 0;
        results_pending = 0;
        held = 0;
        descending = 1'b0;
    end

    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        if (!aresetn) begin
            held = 0;
            descending = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.key = m_tdata[KEY_W-1:0];
                got.value = m_tdata[KEY_W +: VAL_W];
                got.count = m_tdata[KEY_W+VAL_W +: CNT_W];
                got.empty = m_tdata[KEY_W+VAL_W+CNT_W];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d key %0d value %0h",
                             $time, got.status, $signed(got.key), got.value);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.key !== want.key) begin
                        $display("%0t: out_key expected %0d, got %0d",
                                 $time, $signed(want.key), $signed(got.key));
                        mismatch_count++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: out_value expected %0h, got %0h", $time, want.value, got.value);
                        mismatch_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count expected %0d, got %0d", $time, want.count, got.count);
                        mismatch_count++;
                    end
                    if (got.empty !== want.empty) begin
                        $display("%0t: is_empty expected %0b, got %0b", $time, want.empty, got.empty);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_queue_op(req_t'(s_tuser), s_tdata[KEY_W-1:0],
                                                            s_tdata[KEY_W +: VAL_W],
                                                            s_tdata[KEY_W+VAL_W +: CNT_W]));
            end
            if (cfg_we) begin
                descending = cfg_wdata;
            end
        end
        results_pending = expected_results.size();
    end

endmodule

// File: bench/sorted_priority_queue_unit_tb.sv
module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int KEY_W = KEY_W_DEF;
    localparam int VAL_W = VAL_W_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IN_W  = ((KEY_W + VAL_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_W = ((KEY_W + VAL_W + CNT_W + 1 + 7) / 8) * 8;
    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic             cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    int               mismatch_count;
    int               results_pending;
    bit               sender_gaps;
    bit               receiver_gaps;
    bit               pressure_phase;

    sorted_priority_queue_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    priority_queue_checker queue_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("FAIL sorted_priority_queue_unit");
        $finish;
    end

    task automatic send_request(req_t req, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                                logic [CNT_W-1:0] rank);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {{(IN_W-KEY_W-VAL_W-CNT_W){1'b0}}, rank, value, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic set_order(bit descending);
        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        repeat (3) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= descending;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_requests(int count, int insert_pct, int remove_pct);
        int               pick;
        req_t             req;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] rank;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct) begin
                req = REQ_INSERT;
            end else if (pick < insert_pct + remove_pct) begin
                req = REQ_REMOVE;
            end else if (pick < 97) begin
                req = REQ_RANK;
            end else begin
                req = REQ_IGNORE;
            end
            case ($urandom_range(0, 3))
                0: begin
                    key = $urandom_range(0, 6);
                    key = key - 3;
                end
                1: key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
                default: key = $urandom;
            endcase
            rank = $urandom_range(0, 1) ? $urandom_range(0, (1 << CNT_W) - 1) : $urandom_range(1, DEPTH);
            send_request(req, key, $urandom, rank);
        end
    endtask

    initial begin
        int pressure_done;
        int hold;
        pressure_done = 0;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            hold = receiver_gaps ? $urandom_range(0, 16) : 0;
            if (pressure_phase && pressure_done == 0) begin
                hold = 300;
                pressure_done = 1;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_INSERT;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        pressure_phase = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        set_order(1'b0);

        // Refusals on an empty queue, equal keys where the newest must come first, then an insert refused when full.
        send_request(REQ_REMOVE, KEY_MAX, '1, 5'd1);
        send_request(REQ_RANK, '0, '0, 5'd1);
        send_request(REQ_IGNORE, KEY_MIN, '0, 5'd0);
        send_request(REQ_INSERT, KEY_MIN, '0, 5'd0);
        send_request(REQ_INSERT, KEY_MAX, '1, 5'd31);
        send_request(REQ_INSERT, '0, 32'd1, 5'd0);
        send_request(REQ_INSERT, '0, 32'd2, 5'd0);
        send_request(REQ_RANK, KEY_MAX, '1, 5'd0);
        send_request(REQ_RANK, '0, '0, 5'd1);
        send_request(REQ_RANK, '0, '0, 5'd3);
        send_request(REQ_RANK, '0, '0, 5'd5);
        send_request(REQ_RANK, '1, '0, 5'd31);
        send_request(REQ_REMOVE, '0, '0, 5'd0);
        for (int n = 0; n < 13; n++) begin
            send_request(REQ_INSERT, $urandom, $urandom, 5'd0);
        end
        send_request(REQ_INSERT, KEY_MIN, '1, 5'd0);
        send_request(REQ_RANK, '0, '0, 5'd16);

        set_order(1'b1);
        send_random_requests(100, 35, 35);

        set_order(1'b0);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        send_random_requests(100, 30, 45);

        set_order(1'b1);
        receiver_gaps = 1'b1;
        pressure_phase = 1'b1;
        send_random_requests(24, 80, 10);
        pressure_phase = 1'b0;

        set_order(1'b0);
        sender_gaps = 1'b1;
        receiver_gaps = 1'b0;
        send_random_requests(90, 45, 35);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b1;
        send_random_requests(90, 30, 45);

        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        repeat (5) @(negedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("PASS sorted_priority_queue_unit");
        end else begin
            $display("FAIL sorted_priority_queue_unit");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
rtl/core/spq_checker.sv
bench/priority_queue_checker.sv
bench/sorted_priority_queue_unit_tb.sv
